>>> rtl/core/bracket_balance_checker_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bracket balance checker
// Each macro samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BRACKET_BALANCE_CHECKER_UNIT_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, constants and decode functions of the bracket balance checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    localparam int OPQ_DEPTH   = 4;
    localparam int OPQ_AW      = $clog2(OPQ_DEPTH);
    localparam int OPQ_CW      = $clog2(OPQ_DEPTH + 1);

    localparam int RESQ_DEPTH  = 2;
    localparam int RESQ_AW     = $clog2(RESQ_DEPTH);
    localparam int RESQ_CW     = $clog2(RESQ_DEPTH + 1);

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_ROUND  = 2'd0;
    localparam kind_t KIND_SQUARE = 2'd1;
    localparam kind_t KIND_CURLY  = 2'd2;
    localparam kind_t KIND_NONE   = 2'd3;

    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;

    typedef enum logic [1:0] {
        OP_OPEN,
        OP_CLOSE,
        OP_END
    } op_code_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MISMATCH = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_UNCLOSED = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    typedef struct packed {
        op_code_t code;
        kind_t    kind;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } op_chan_t;

    typedef struct packed {
        logic    balanced;
        status_t status;
    } result_t;

    function automatic kind_t opener_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            CH_OPEN_ROUND:  k = KIND_ROUND;
            CH_OPEN_SQUARE: k = KIND_SQUARE;
            CH_OPEN_CURLY:  k = KIND_CURLY;
            default:        k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic kind_t closer_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            CH_CLOSE_ROUND:  k = KIND_ROUND;
            CH_CLOSE_SQUARE: k = KIND_SQUARE;
            CH_CLOSE_CURLY:  k = KIND_CURLY;
            default:         k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/bbc_ram.sv
// ----------------------------------------------------------------------------
// bbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/bbc_front.sv
// ----------------------------------------------------------------------------
// bbc_front
// Accepts input beats, decodes brackets and queues the resulting operations.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_front
    import bbc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] symbol,
    input  wire logic       end_marker,
    input  wire logic       push,
    output logic            full,
    output op_chan_t        op_out,
    input  wire logic       op_pop
);

    op_t               q_mem_reg [OPQ_DEPTH];
    logic [OPQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OPQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OPQ_CW-1:0] count_reg, count_next;

    kind_t k_open;
    kind_t k_close;
    logic  keep;
    logic  wr_en;
    logic  rd_en;
    op_t   new_op;

    always_comb
    begin
        k_open  = opener_kind(symbol);
        k_close = closer_kind(symbol);
        // Bytes that are neither brackets nor an end never reach the stack.
        keep    = end_marker || (k_open != KIND_NONE) || (k_close != KIND_NONE);
        if (end_marker)
        begin
            new_op.code = OP_END;
            new_op.kind = KIND_NONE;
        end
        else if (k_open != KIND_NONE)
        begin
            new_op.code = OP_OPEN;
            new_op.kind = k_open;
        end
        else
        begin
            new_op.code = OP_CLOSE;
            new_op.kind = k_close;
        end
    end

    assign full  = (count_reg == OPQ_CW'(OPQ_DEPTH));
    assign wr_en = push && !full && keep;
    assign rd_en = op_pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == OPQ_AW'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == OPQ_AW'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem_reg[wr_ptr_reg] <= new_op;
        end
    end

    assign op_out.valid = (count_reg != '0);
    assign op_out.op    = q_mem_reg[rd_ptr_reg];

endmodule

`default_nettype wire

>>> rtl/core/bbc_back.sv
// ----------------------------------------------------------------------------
// bbc_back
// Stack engine: forms verdicts, one operation per cycle; ends wait on res_full.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_back
    import bbc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire op_chan_t op_in,
    output logic          op_pop,
    output logic          res_push,
    output result_t       res,
    input  wire logic     res_full
);

    logic [SP_W-1:0]   sp_reg, sp_next;
    status_t           err_reg, err_next;
    kind_t             top_reg, top_next;
    logic              byp_reg, byp_next;
    kind_t             byp_data_reg;

    logic              take;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    kind_t             rd_data;
    kind_t             below;
    status_t           verdict;

    // The top entry lives in top_reg; the RAM holds everything beneath it.
    // The RAM is always read at the entry just below the next top, and a write
    // to that same entry is forwarded through the bypass register.
    bbc_ram #(
        .WIDTH ($bits(kind_t)),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (top_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign below = byp_reg ? byp_data_reg : rd_data;

    assign take   = op_in.valid && !((op_in.op.code == OP_END) && res_full);
    assign op_pop = take;

    always_comb
    begin
        verdict = err_reg;
        if ((err_reg == ST_OK) && (sp_reg != '0))
        begin
            verdict = ST_UNCLOSED;
        end
    end

    assign res.status   = verdict;
    assign res.balanced = (verdict == ST_OK);

    always_comb
    begin
        sp_next  = sp_reg;
        err_next = err_reg;
        top_next = top_reg;
        wr_en    = 1'b0;
        wr_addr  = ADDR_W'(sp_reg - 1'b1);
        res_push = 1'b0;
        if (take)
        begin
            unique case (op_in.op.code)
                OP_END:
                begin
                    res_push = 1'b1;
                    sp_next  = '0;
                    err_next = ST_OK;
                end
                OP_OPEN:
                begin
                    if (err_reg == ST_OK)
                    begin
                        if (sp_reg == SP_W'(STACK_DEPTH))
                        begin
                            err_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            wr_en    = (sp_reg != '0);
                            top_next = op_in.op.kind;
                            sp_next  = sp_reg + 1'b1;
                        end
                    end
                end
                OP_CLOSE:
                begin
                    if (err_reg == ST_OK)
                    begin
                        if (sp_reg == '0)
                        begin
                            err_next = ST_EMPTY;
                        end
                        else if (top_reg != op_in.op.kind)
                        begin
                            err_next = ST_MISMATCH;
                        end
                        else
                        begin
                            top_next = below;
                            sp_next  = sp_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                    sp_next = sp_reg;
                end
            endcase
        end
        rd_addr  = ADDR_W'(sp_next - SP_W'(2));
        byp_next = wr_en && (wr_addr == rd_addr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg  <= '0;
            err_reg <= ST_OK;
            byp_reg <= 1'b0;
        end
        else
        begin
            sp_reg  <= sp_next;
            err_reg <= err_next;
            byp_reg <= byp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        byp_data_reg <= top_reg;
    end

endmodule

`default_nettype wire

>>> rtl/core/bbc_resq.sv
// ----------------------------------------------------------------------------
// bbc_resq
// Small result queue between the stack engine and the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_resq
    import bbc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire result_t wr_data,
    output logic         full,
    output logic         empty,
    input  wire logic    pop,
    output result_t      rd_data
);

    result_t            q_mem_reg [RESQ_DEPTH];
    logic [RESQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RESQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RESQ_CW-1:0] count_reg, count_next;
    logic               do_wr;
    logic               do_rd;

    assign full  = (count_reg == RESQ_CW'(RESQ_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == RESQ_AW'(RESQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == RESQ_AW'(RESQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = q_mem_reg[rd_ptr_reg];

endmodule

`default_nettype wire

>>> rtl/core/bracket_balance_checker_unit.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker_unit
// Checks a byte stream for balanced round, square and curly brackets.
// ----------------------------------------------------------------------------
//  Channel  | Handshake    | Payload
//  ---------+--------------+----------------------------
//  input    | push / full  | symbol[7:0], end_marker
//  result   | pop / empty  | balanced, status[2:0]
//
// One input beat is taken per cycle while the operation queue is not full;
// the stack engine retires one operation per cycle unless an end waits on a
// full result queue, with the top entry in a register and a registered RAM
// read of the entry beneath it kept in step with the stack pointer. An end
// beat's verdict goes from the operation queue through the stack engine into
// the result queue, whose head the result ports show. Reset clears the
// pointers and error state; the stack RAM needs no clearing pass. Either
// side may stall without holding up the other until its queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_balance_checker_unit
    import bbc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] symbol,
    input  wire logic       end_marker,
    input  wire logic       push,
    output logic            full,
    output logic            balanced,
    output logic [2:0]      status,
    output logic            empty,
    input  wire logic       pop
);

    op_chan_t op_chan;
    logic     op_pop;
    logic     res_push;
    logic     res_full;
    result_t  res_in;
    result_t  res_out;

    bbc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .symbol     (symbol),
        .end_marker (end_marker),
        .push       (push),
        .full       (full),
        .op_out     (op_chan),
        .op_pop     (op_pop)
    );

    bbc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_in    (op_chan),
        .op_pop   (op_pop),
        .res_push (res_push),
        .res      (res_in),
        .res_full (res_full)
    );

    bbc_resq u_resq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .empty   (empty),
        .pop     (pop),
        .rd_data (res_out)
    );

    assign balanced = res_out.balanced;
    assign status   = res_out.status;

endmodule

`default_nettype wire

>>> rtl/core/bbc_checker.sv
// ----------------------------------------------------------------------------
// bbc_checker
// Port-level checks on the results of the bracket balance checker.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bracket_balance_checker_unit_defines.svh"

module bbc_checker
    import bbc_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       full,
    input wire logic       balanced,
    input wire logic [2:0] status,
    input wire logic       empty,
    input wire logic       pop
);

    // The queue flags are always driven once reset has been released.
    `BBC_ASSERT_SAME(a_flags_known, 1'b1, !$isunknown(full) && !$isunknown(empty), "full or empty is unknown")

    // A verdict is balanced exactly when its status reports no problem.
    `BBC_ASSERT_SAME(a_balanced_matches_status, !empty, balanced == (status == ST_OK), "balanced disagrees with status")

    // Only the five defined status codes may ever be shown.
    `BBC_ASSERT_SAME(a_status_in_range, !empty, status <= ST_OVERFLOW, "undefined status code")

    // A waiting result holds until it is taken.
    `BBC_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(status) && $stable(balanced), "waiting result changed")

endmodule

bind bracket_balance_checker_unit bbc_checker u_bbc_checker (.*);

`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the bracket balance checker
// A short table of hand-written texts runs first. Random texts follow:
// well-formed ones, ones broken on purpose, and noise. One deep text per
// phase fills the stack to its full depth, and in later phases past it.
// Verdicts are checked against the table or a predictor fed accepted beats.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bbc_pkg::*;

    localparam int BEATS_PER_PHASE = 380;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int NEST_LIMIT      = 12;
    localparam int DIR_ROWS        = 23;

    typedef struct packed {
        logic [7:0] sym;
        logic       endm;
        logic       typed;
        result_t    want;
    } dir_row_t;

    logic       clk;
    logic       rst_n      = 1'b0;
    logic [7:0] symbol     = '0;
    logic       end_marker = 1'b0;
    logic       push       = 1'b0;
    logic       pop        = 1'b0;
    logic       full;
    logic       balanced;
    logic [2:0] status;
    logic       empty;

    // Predictor state: kinds of the open brackets, their count, the first error.
    kind_t      kind_stack [STACK_DEPTH];
    int         open_count = 0;
    status_t    first_error = ST_OK;

    result_t    verdict_q [$];
    logic [7:0] text_bytes [$];
    int         err_count = 0;
    int         beats_counted = 0;
    int         cycle_count = 0;
    int         send_idle_pct = 9;
    int         rcv_idle_pct = 55;

    // Short texts whose verdicts can be read off directly, plus one left
    // to the predictor.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{8'h00,           1'b1, 1'b1, '{1'b1, ST_OK}},
        '{CH_OPEN_ROUND,   1'b0, 1'b0, '{1'b0, ST_OK}},
        '{CH_OPEN_SQUARE,  1'b0, 1'b0, '{1'b0, ST_OK}},
        '{CH_OPEN_CURLY,   1'b0, 1'b0, '{1'b0, ST_OK}},
        '{CH_CLOSE_CURLY,  1'b0, 1'b0, '{1'b0, ST_OK}},
        '{CH_CLOSE_SQUARE, 1'b0, 1'b0, '{1'b0, ST_OK}},
        '{CH_CLOSE_ROUND,  1'b0, 1'b0, '{1'b0, ST_OK}},
        '{8'hA5,           1'b1, 1'b1, '{1'b1, ST_OK}},
        '{CH_OPEN_ROUND,   1'b0, 1'b0, '{1'b0, ST_OK}},
        '{CH_CLOSE_SQUARE, 1'b0, 1'b0, '{1'b0, ST_OK}},
        '{CH_CLOSE_ROUND,  1'b0, 1'b0, '{1'b0, ST_OK}},
        '{8'h00,           1'b1, 1'b1, '{1'b0, ST_MISMATCH}},
        '{CH_CLOSE_CURLY,  1'b0, 1'b0, '{1'b0, ST_OK}},
        '{CH_OPEN_ROUND,   1'b0, 1'b0, '{1'b0, ST_OK}},
        '{8'hFF,           1'b1, 1'b1, '{1'b0, ST_EMPTY}},
        '{CH_OPEN_SQUARE,  1'b0, 1'b0, '{1'b0, ST_OK}},
        '{8'hFF,           1'b0, 1'b0, '{1'b0, ST_OK}},
        '{8'h00,           1'b0, 1'b0, '{1'b0, ST_OK}},
        '{8'h5A,           1'b1, 1'b1, '{1'b0, ST_UNCLOSED}},
        '{CH_OPEN_CURLY,   1'b0, 1'b0, '{1'b0, ST_OK}},
        '{CH_CLOSE_CURLY,  1'b0, 1'b0, '{1'b0, ST_OK}},
        '{8'h41,           1'b0, 1'b0, '{1'b0, ST_OK}},
        '{CH_OPEN_ROUND,   1'b1, 1'b0, '{1'b0, ST_OK}}
    };

    bracket_balance_checker_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .symbol     (symbol),
        .end_marker (end_marker),
        .push       (push),
        .full       (full),
        .balanced   (balanced),
        .status     (status),
        .empty      (empty),
        .pop        (pop)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic kind_t open_kind(input logic [7:0] c);
        if (c == CH_OPEN_ROUND) return KIND_ROUND;
        if (c == CH_OPEN_SQUARE) return KIND_SQUARE;
        if (c == CH_OPEN_CURLY) return KIND_CURLY;
        return KIND_NONE;
    endfunction

    function automatic kind_t close_kind(input logic [7:0] c);
        if (c == CH_CLOSE_ROUND) return KIND_ROUND;
        if (c == CH_CLOSE_SQUARE) return KIND_SQUARE;
        if (c == CH_CLOSE_CURLY) return KIND_CURLY;
        return KIND_NONE;
    endfunction

    function automatic logic [7:0] open_char(input kind_t k);
        case (k)
            KIND_ROUND:  return CH_OPEN_ROUND;
            KIND_SQUARE: return CH_OPEN_SQUARE;
            default:     return CH_OPEN_CURLY;
        endcase
    endfunction

    function automatic logic [7:0] close_char(input kind_t k);
        case (k)
            KIND_ROUND:  return CH_CLOSE_ROUND;
            KIND_SQUARE: return CH_CLOSE_SQUARE;
            default:     return CH_CLOSE_CURLY;
        endcase
    endfunction

    // Advances the predictor by one accepted beat; returns 1 when the beat
    // yields a verdict, which is then left in v.
    function automatic bit predict_verdict(input logic [7:0] s, input logic e,
                                           output result_t v);
        kind_t k;
        v = '{1'b0, ST_OK};
        if (e)
        begin
            v.status = first_error;
            if (first_error == ST_OK && open_count != 0)
                v.status = ST_UNCLOSED;
            v.balanced = (v.status == ST_OK);
            open_count = 0;
            first_error = ST_OK;
            return 1'b1;
        end
        if (first_error != ST_OK)
            return 1'b0;
        k = open_kind(s);
        if (k != KIND_NONE)
        begin
            if (open_count >= STACK_DEPTH)
                first_error = ST_OVERFLOW;
            else
            begin
                kind_stack[open_count] = k;
                open_count++;
            end
            return 1'b0;
        end
        k = close_kind(s);
        if (k != KIND_NONE)
        begin
            if (open_count == 0)
                first_error = ST_EMPTY;
            else if (kind_stack[open_count - 1] != k)
                first_error = ST_MISMATCH;
            else
                open_count--;
        end
        return 1'b0;
    endfunction

    // Offers one beat and returns at the edge where it is taken. The push
    // line is only lowered when the sender idles, so that it never gets two
    // assignments in one time step.
    task automatic send_beat(input logic [7:0] s, input logic e,
                             input logic typed, input result_t typed_v);
        result_t v;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        symbol     <= s;
        end_marker <= e;
        push       <= 1'b1;
        do @(posedge clk); while (full);
        beats_counted++;
        if (predict_verdict(s, e, v))
            verdict_q.push_back(typed ? typed_v : v);
    endtask

    // Holds the sender back until every verdict owed has come out.
    task automatic drain();
        push <= 1'b0;
        do @(posedge clk); while (verdict_q.size() != 0);
    endtask

    task automatic send_text();
        foreach (text_bytes[i])
            send_beat(text_bytes[i], 1'b0, 1'b0, '{1'b0, ST_OK});
        send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0, '{1'b0, ST_OK});
    endtask

    // Builds a random text: mostly well formed, some broken on purpose,
    // some pure noise.
    task automatic build_text();
        kind_t      opened [$];
        int         closers [$];
        int         flavour;
        int         steps;
        int         pick;
        kind_t      k;
        logic [7:0] b;
        text_bytes.delete();
        flavour = $urandom_range(0, 9);
        steps = $urandom_range(0, 24);
        if (flavour == 9)
        begin
            repeat (steps)
            begin
                if ($urandom_range(0, 1) == 0)
                    b = 8'($urandom_range(0, 255));
                else if ($urandom_range(0, 1) == 0)
                    b = open_char(kind_t'($urandom_range(0, 2)));
                else
                    b = close_char(kind_t'($urandom_range(0, 2)));
                text_bytes.push_back(b);
            end
            return;
        end
        repeat (steps)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    if (opened.size() < NEST_LIMIT)
                    begin
                        k = kind_t'($urandom_range(0, 2));
                        opened.push_back(k);
                        text_bytes.push_back(open_char(k));
                    end
                end
                1:
                begin
                    if (opened.size() > 0)
                        text_bytes.push_back(close_char(opened.pop_back()));
                end
                default:
                begin
                    // All bracket codes sit below 8'h80, so flipping the top
                    // bit turns any of them into plain text.
                    b = 8'($urandom_range(0, 255));
                    if (open_kind(b) != KIND_NONE || close_kind(b) != KIND_NONE)
                        b = b ^ 8'h80;
                    text_bytes.push_back(b);
                end
            endcase
        end
        // One flavour leaves its openers unclosed.
        if (flavour != 7)
            while (opened.size() > 0)
                text_bytes.push_back(close_char(opened.pop_back()));
        if (flavour == 6)
        begin
            foreach (text_bytes[i])
                if (close_kind(text_bytes[i]) != KIND_NONE)
                    closers.push_back(i);
            if (closers.size() > 0)
            begin
                pick = closers[$urandom_range(0, closers.size() - 1)];
                k = close_kind(text_bytes[pick]);
                text_bytes[pick] = close_char(kind_t'((k + $urandom_range(1, 2)) % 3));
            end
        end
        if (flavour == 8)
            text_bytes.push_front(close_char(kind_t'($urandom_range(0, 2))));
    endtask

    // Opens depth brackets of random kind, then closes them in reverse order.
    task automatic build_nest(input int depth);
        kind_t opened [$];
        kind_t k;
        text_bytes.delete();
        repeat (depth)
        begin
            k = kind_t'($urandom_range(0, 2));
            opened.push_back(k);
            text_bytes.push_back(open_char(k));
        end
        while (opened.size() > 0)
            text_bytes.push_back(close_char(opened.pop_back()));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("verdict beat with nothing expected: balanced %0d, status %0d",
                       balanced, status);
                err_count++;
            end
            else
            begin
                if (balanced !== verdict_q[0].balanced)
                begin
                    $error("balanced: expected %0d, actual %0d",
                           verdict_q[0].balanced, balanced);
                    err_count++;
                end
                if (status !== verdict_q[0].status)
                begin
                    $error("status: expected %0d, actual %0d",
                           verdict_q[0].status, status);
                    err_count++;
                end
                void'(verdict_q.pop_front());
            end
        end
        pop <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int depth;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].sym, dir_rows[i].endm, dir_rows[i].typed,
                      dir_rows[i].want);
        beats_counted = 0;

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 9;
                    rcv_idle_pct = 55;
                    depth = STACK_DEPTH;
                end
                1:
                begin
                    send_idle_pct = 55;
                    rcv_idle_pct = 9;
                    depth = STACK_DEPTH + 1;
                end
                default:
                begin
                    send_idle_pct = 0;
                    rcv_idle_pct = 0;
                    depth = STACK_DEPTH + $urandom_range(1, 3);
                end
            endcase
            // Each phase fills the stack once: exactly to the brim first,
            // then one or more brackets over it.
            build_nest(depth);
            send_text();
            while (beats_counted < BEATS_PER_PHASE * (phase + 1))
            begin
                build_text();
                send_text();
                if ($urandom_range(0, 39) == 0)
                    drain();
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
